// ----- rtl/cca_pkg.sv -----
// Shared types and constants for the canonical code assigner.
package cca_pkg;

  localparam int LEN_W  = 6;
  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic             action;
    logic [SYM_W-1:0] symbol;
    logic [LEN_W-1:0] code_length;
  } in_t;

  typedef struct packed {
    logic              has_code;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_len;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_WALK,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/canonical_code_assigner.sv -----
// Canonical code assigner: length table in RAM, query by sequential scan and length walk.
// A load writes the length RAM straight from IDLE. A query steps through LOOKUP, SCAN, WALK and
// DONE; an unused or out-of-range symbol goes from LOOKUP straight to DONE.
// The scan uses the single read port of the length RAM, one entry per cycle, and the walk then
// takes one length level per cycle through the shared accumulate-and-shift step.
// After reset the block clears the RAM and holds in_stall high meanwhile.
module canonical_code_assigner #(
  parameter int NUM_SYMBOLS  = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cca_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cca_pkg::out_t out_data
);

  localparam int LEN_CAP = (MAX_CODE_LEN > 63) ? 63 : MAX_CODE_LEN;
  localparam int IDX_W   = $clog2(NUM_SYMBOLS);
  localparam int CNT_W   = $clog2(NUM_SYMBOLS + 1);

  // length RAM
  logic [cca_pkg::LEN_W-1:0] mem [NUM_SYMBOLS];
  logic [cca_pkg::LEN_W-1:0] rd_data_r;
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_wa;
  logic [cca_pkg::LEN_W-1:0] mem_wd;
  logic [IDX_W-1:0]          mem_ra;

  cca_pkg::state_t state_r, state_nxt;

  logic [IDX_W-1:0]          scan_r, scan_nxt;
  logic [IDX_W-1:0]          sym_r, sym_nxt;
  logic                      sym_ok_r, sym_ok_nxt;
  logic [cca_pkg::LEN_W-1:0] tlen_r, tlen_nxt;
  logic [cca_pkg::LEN_W-1:0] lvl_r, lvl_nxt;
  logic [CNT_W-1:0]          acc_r, acc_nxt;
  logic [CNT_W-1:0]          rank_r, rank_nxt;
  logic                      hit_r, hit_nxt;
  logic [CNT_W-1:0]          cnt_r   [LEN_CAP+1];
  logic [CNT_W-1:0]          cnt_nxt [LEN_CAP+1];
  logic                      out_valid_r, out_valid_nxt;
  cca_pkg::out_t             out_data_r, out_data_nxt;

  logic                      in_acc;
  logic                      in_range;
  logic [cca_pkg::LEN_W-1:0] sat_len;
  logic [CNT_W-1:0]          sum;
  logic [CNT_W-1:0]          code_full;
  logic [CNT_W-1:0]          code_mask;

  assign in_stall  = (state_r != cca_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_range = (32'(in_data.symbol) < 32'(NUM_SYMBOLS));
  assign sat_len  = (32'(in_data.code_length) > 32'(LEN_CAP)) ?
                    cca_pkg::LEN_W'(LEN_CAP) : in_data.code_length;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cca_pkg::ST_CLEAR;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r      <= sym_nxt;
    sym_ok_r   <= sym_ok_nxt;
    tlen_r     <= tlen_nxt;
    lvl_r      <= lvl_nxt;
    acc_r      <= acc_nxt;
    rank_r     <= rank_nxt;
    hit_r      <= hit_nxt;
    out_data_r <= out_data_nxt;
    for (int i = 0; i <= LEN_CAP; i++) begin
      cnt_r[i] <= cnt_nxt[i];
    end
  end

  // final code: accumulated base plus rank, kept to its low tlen bits
  always_comb begin
    code_full = acc_r + rank_r;
    for (int i = 0; i < CNT_W; i++) begin
      code_mask[i] = (i < int'(tlen_r));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    sym_nxt       = sym_r;
    sym_ok_nxt    = sym_ok_r;
    tlen_nxt      = tlen_r;
    lvl_nxt       = lvl_r;
    acc_nxt       = acc_r;
    rank_nxt      = rank_r;
    hit_nxt       = hit_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    for (int i = 0; i <= LEN_CAP; i++) begin
      cnt_nxt[i] = cnt_r[i];
    end
    mem_we = 1'b0;
    mem_wa = IDX_W'(in_data.symbol);
    mem_wd = sat_len;
    mem_ra = IDX_W'(in_data.symbol);
    sum    = acc_r + cnt_r[LEN_CAP];

    unique case (state_r)
      cca_pkg::ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_wa   = scan_r;
        mem_wd   = '0;
        scan_nxt = IDX_W'(scan_r + 1'b1);
        if (scan_r == IDX_W'(NUM_SYMBOLS - 1)) begin
          state_nxt = cca_pkg::ST_IDLE;
        end
      end
      cca_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.action == cca_pkg::ACT_LOAD) begin
            mem_we = in_range;
          end else begin
            sym_nxt    = IDX_W'(in_data.symbol);
            sym_ok_nxt = in_range;
            state_nxt  = cca_pkg::ST_LOOKUP;
          end
        end
      end
      cca_pkg::ST_LOOKUP: begin
        // target length is on the read port; issue the first scan read
        mem_ra   = '0;
        scan_nxt = '0;
        tlen_nxt = rd_data_r;
        rank_nxt = '0;
        acc_nxt  = '0;
        lvl_nxt  = cca_pkg::LEN_W'(LEN_CAP);
        for (int i = 0; i <= LEN_CAP; i++) begin
          cnt_nxt[i] = '0;
        end
        if (!sym_ok_r || rd_data_r == '0) begin
          hit_nxt   = 1'b0;
          state_nxt = cca_pkg::ST_DONE;
        end else begin
          state_nxt = cca_pkg::ST_SCAN;
        end
      end
      cca_pkg::ST_SCAN: begin
        mem_ra   = IDX_W'(scan_r + 1'b1);
        scan_nxt = IDX_W'(scan_r + 1'b1);
        // count longer codes per length, and same-length symbols above the target
        for (int i = 0; i <= LEN_CAP; i++) begin
          if (int'(rd_data_r) == i && rd_data_r > tlen_r) begin
            cnt_nxt[i] = cnt_r[i] + 1'b1;
          end
        end
        if (rd_data_r == tlen_r && scan_r > sym_r) begin
          rank_nxt = rank_r + 1'b1;
        end
        if (scan_r == IDX_W'(NUM_SYMBOLS - 1)) begin
          state_nxt = cca_pkg::ST_WALK;
        end
      end
      cca_pkg::ST_WALK: begin
        if (lvl_r > tlen_r) begin
          // add this level's count, then drop one bit of length
          acc_nxt = sum >> 1;
          lvl_nxt = lvl_r - 1'b1;
          for (int i = LEN_CAP; i >= 1; i--) begin
            cnt_nxt[i] = cnt_r[i-1];
          end
          cnt_nxt[0] = '0;
        end else begin
          hit_nxt   = 1'b1;
          state_nxt = cca_pkg::ST_DONE;
        end
      end
      cca_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.has_code  = hit_r;
          out_data_nxt.code_bits = hit_r ? cca_pkg::CODE_W'(code_full & code_mask) : '0;
          out_data_nxt.code_len  = hit_r ? tlen_r : '0;
          state_nxt              = cca_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cca_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
